### rtl/core/matrix_inverse_3x3_assert.svh
// Assertion macros for the 3x3 matrix inverse block.
// Used by the top level only; no other dependencies.
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH
`ifndef SYNTHESIS
`define MI_ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define MI_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assert failed");
`else
`define MI_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define MI_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

### rtl/core/mi3_pkg.sv
// Package for the 3x3 matrix inverse: payload structs, widths, pipeline depth.
// No dependencies.
`default_nettype none
package mi3_pkg;
  localparam int unsigned ElemW  = 32;
  localparam int unsigned EpsW   = 31;
  localparam int unsigned CofW   = 65;
  localparam int unsigned DetW   = 98;
  localparam int unsigned NumW   = CofW + 32;
  localparam int unsigned QW     = 33;
  localparam int unsigned DivLat = QW;
  localparam logic [EpsW-1:0] EpsReset = EpsW'(1);

  typedef struct packed {
    logic signed [ElemW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  } mi3_in_t;

  typedef struct packed {
    logic signed [ElemW-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
    logic singular;
    logic saturated;
  } mi3_out_t;

  typedef struct packed {
    logic valid;
    logic singular;
    logic neg_det;
  } mi3_ctl_t;
endpackage
`default_nettype wire

### rtl/core/mi3_lane.sv
// One divider lane: pipelined restoring division of |cofactor|*2^32 by |det|.
// Produces a saturated signed Q16.16 element. Depends on mi3_pkg.
`default_nettype none
module mi3_lane (
  input  wire logic clk_i,
  input  wire logic signed [mi3_pkg::CofW-1:0] cof_i,
  input  wire logic [mi3_pkg::DetW-1:0] mag_i,
  input  wire logic neg_det_i,
  output logic signed [mi3_pkg::ElemW-1:0] elem_o,
  output logic sat_o
);
  import mi3_pkg::*;
  localparam int unsigned RW = DetW + 1;

  // Per-stage registers: partial remainder, remaining numerator bits, quotient.
  logic [RW-1:0]   rem_q [DivLat+1];
  logic [NumW-1:0] num_q [DivLat+1];
  logic [DetW-1:0] den_q [DivLat+1];
  logic [QW-1:0]   quo_q [DivLat+1];
  logic            ovf_q [DivLat+1];
  logic            neg_q [DivLat+1];
  logic [NumW-1:0] num_abs;
  logic [CofW-1:0] cof_abs;

  // Quotient bits above bit 32 are nonzero iff top of numerator >= den.
  always_comb begin
    cof_abs = cof_i[CofW-1] ? CofW'(-cof_i) : CofW'(cof_i);
    num_abs = {cof_abs, 32'd0};
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= RW'(num_abs[NumW-1:QW]);
    num_q[0] <= num_abs;
    den_q[0] <= mag_i;
    quo_q[0] <= '0;
    ovf_q[0] <= ({{(RW-(NumW-QW)){1'b0}}, num_abs[NumW-1:QW]} >= {1'b0, mag_i});
    neg_q[0] <= cof_i[CofW-1] ^ neg_det_i;
  end

  // One quotient bit per stage.
  for (genvar s = 0; s < DivLat; s++) begin : g_stage
    logic [RW-1:0] trial;
    always_comb trial = {rem_q[s][RW-2:0], num_q[s][QW-1-s]};
    always_ff @(posedge clk_i) begin
      num_q[s+1] <= num_q[s];
      den_q[s+1] <= den_q[s];
      ovf_q[s+1] <= ovf_q[s];
      neg_q[s+1] <= neg_q[s];
      if (trial >= {1'b0, den_q[s]}) begin
        rem_q[s+1] <= trial - {1'b0, den_q[s]};
        quo_q[s+1] <= {quo_q[s][QW-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= trial;
        quo_q[s+1] <= {quo_q[s][QW-2:0], 1'b0};
      end
    end
  end

  // Sign and saturation.
  always_comb begin
    logic [QW-1:0] q;
    q = quo_q[DivLat];
    if (neg_q[DivLat]) begin
      if (ovf_q[DivLat] || q > QW'(33'h080000000)) begin
        elem_o = 32'sh80000000;
        sat_o  = 1'b1;
      end else begin
        elem_o = ElemW'(-q);
        sat_o  = 1'b0;
      end
    end else begin
      if (ovf_q[DivLat] || q > QW'(33'h07FFFFFFF)) begin
        elem_o = 32'sh7FFFFFFF;
        sat_o  = 1'b1;
      end else begin
        elem_o = ElemW'(q);
        sat_o  = 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/mi3_front.sv
// Front end: cofactors and determinant in six registered stages.
// Depends on mi3_pkg.
`default_nettype none
module mi3_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic vld_i,
  input  wire mi3_pkg::mi3_in_t m_i,
  input  wire logic [mi3_pkg::EpsW-1:0] eps_i,
  output logic signed [mi3_pkg::CofW-1:0] cof_o [9],
  output logic [mi3_pkg::DetW-1:0] mag_o,
  output mi3_pkg::mi3_ctl_t ctl_o
);
  import mi3_pkg::*;
  localparam int unsigned ProdW = CofW;

  logic signed [ElemW-1:0] e [9];
  logic signed [63:0] p_q [18];
  logic signed [ElemW-1:0] r0_q [3];
  logic signed [ElemW-1:0] r1_q [3];
  logic signed [CofW-1:0] c_q [9];
  logic signed [ProdW-1:0] lo_q [3];
  logic signed [ProdW-1:0] hi_q [3];
  logic signed [DetW-1:0] d_q [3];
  logic signed [DetW-1:0] det_q;
  logic [DetW-1:0] det_abs;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic neg_q, sing_q;
  logic signed [CofW-1:0] c3_q [9];
  logic signed [CofW-1:0] c4_q [9];
  logic signed [CofW-1:0] c5_q [9];

  // Full-width signed product of two elements.
  function automatic logic signed [63:0] mul32(input logic signed [ElemW-1:0] a,
                                               input logic signed [ElemW-1:0] b);
    return 64'(a) * 64'(b);
  endfunction

  always_comb begin
    e[0] = m_i.a00; e[1] = m_i.a01; e[2] = m_i.a02;
    e[3] = m_i.a10; e[4] = m_i.a11; e[5] = m_i.a12;
    e[6] = m_i.a20; e[7] = m_i.a21; e[8] = m_i.a22;
  end

  // Stage 1: eighteen 32x32 products.
  always_ff @(posedge clk_i) begin
    p_q[0]  <= mul32(e[4], e[8]); p_q[1]  <= mul32(e[5], e[7]);
    p_q[2]  <= mul32(e[2], e[7]); p_q[3]  <= mul32(e[1], e[8]);
    p_q[4]  <= mul32(e[1], e[5]); p_q[5]  <= mul32(e[2], e[4]);
    p_q[6]  <= mul32(e[5], e[6]); p_q[7]  <= mul32(e[3], e[8]);
    p_q[8]  <= mul32(e[0], e[8]); p_q[9]  <= mul32(e[2], e[6]);
    p_q[10] <= mul32(e[2], e[3]); p_q[11] <= mul32(e[0], e[5]);
    p_q[12] <= mul32(e[3], e[7]); p_q[13] <= mul32(e[4], e[6]);
    p_q[14] <= mul32(e[1], e[6]); p_q[15] <= mul32(e[0], e[7]);
    p_q[16] <= mul32(e[0], e[4]); p_q[17] <= mul32(e[1], e[3]);
    r0_q[0] <= e[0]; r0_q[1] <= e[1]; r0_q[2] <= e[2];
  end

  // Stage 2: cofactors.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) begin
      c_q[k] <= CofW'(p_q[2*k]) - CofW'(p_q[2*k+1]);
    end
    r1_q <= r0_q;
  end

  // Stage 3: first-row products, each split into a low and a high 32x33 half.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      lo_q[j] <= ProdW'(r1_q[j]) * ProdW'($signed({1'b0, c_q[3*j][31:0]}));
      hi_q[j] <= ProdW'(r1_q[j]) * ProdW'($signed(c_q[3*j][CofW-1:32]));
    end
    c3_q <= c_q;
  end

  // Stage 4: recombine the halves of each first-row product.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      d_q[j] <= (DetW'(hi_q[j]) <<< 32) + DetW'(lo_q[j]);
    end
    c4_q <= c3_q;
  end

  // Stage 5: determinant.
  always_ff @(posedge clk_i) begin
    det_q <= d_q[0] + d_q[1] + d_q[2];
    c5_q  <= c4_q;
  end

  // Stage 6: magnitude, sign and singular test.
  always_comb det_abs = det_q[DetW-1] ? DetW'(-det_q) : DetW'(det_q);
  always_ff @(posedge clk_i) begin
    mag_o  <= det_abs;
    neg_q  <= det_q[DetW-1];
    sing_q <= (det_abs < DetW'({eps_i, 32'd0})) || (det_q == '0);
    cof_o  <= c5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0;
    end else begin
      v1_q <= vld_i; v2_q <= v1_q; v3_q <= v2_q;
      v4_q <= v3_q; v5_q <= v4_q; v6_q <= v5_q;
    end
  end

  // Control word that travels with the lane inputs.
  always_comb begin
    ctl_o.valid    = v6_q;
    ctl_o.singular = sing_q;
    ctl_o.neg_det  = neg_q;
  end
endmodule
`default_nettype wire

### rtl/core/matrix_inverse_3x3.sv
// Top level of the 3x3 matrix inverse: front end, nine divider lanes, merge.
// Depends on mi3_pkg, mi3_front, mi3_lane and matrix_inverse_3x3_assert.svh.
//
//  channel  | signals                        | handshake
//  input    | start, busy, in_i              | accepted when start && !busy
//  result   | done_o, out_o                  | one cycle, cannot be held off
//  config   | cfg_we_i, cfg_wdata_i          | written when cfg_we_i
//
// One matrix per cycle; a result passes through the six front-end stages and then
// the divider lanes (input register plus 33 steps).
// busy is always low after reset, so the sender never stalls; the receiver cannot.
// Reset clears the valid bits and sets eps_q to 1.
`default_nettype none
`include "matrix_inverse_3x3_assert.svh"
module matrix_inverse_3x3 (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic busy,
  input  wire mi3_pkg::mi3_in_t in_i,
  output logic done_o,
  output mi3_pkg::mi3_out_t out_o,
  input  wire logic cfg_we_i,
  input  wire logic [mi3_pkg::EpsW-1:0] cfg_wdata_i
);
  import mi3_pkg::*;
  logic [EpsW-1:0] eps_q;
  logic signed [CofW-1:0] cof [9];
  logic [DetW-1:0] mag;
  mi3_ctl_t ctl;
  logic signed [ElemW-1:0] el [9];
  logic sat [9];
  logic [DivLat:0] vld_q;
  logic [DivLat:0] sing_q;

  assign busy = 1'b0;

  // Epsilon register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) eps_q <= EpsReset;
    else if (cfg_we_i) eps_q <= cfg_wdata_i;
  end

  mi3_front u_front (
    .clk_i, .rst_ni, .vld_i(start && !busy), .m_i(in_i), .eps_i(eps_q),
    .cof_o(cof), .mag_o(mag), .ctl_o(ctl)
  );

  // Nine lanes; a singular matrix feeds a divisor of one to keep lanes defined.
  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_lane u_lane (
      .clk_i, .cof_i(cof[k]), .mag_i(ctl.singular ? DetW'(1) : mag),
      .neg_det_i(ctl.neg_det), .elem_o(el[k]), .sat_o(sat[k])
    );
  end

  // Control shadow for the lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0; sing_q <= '0;
    end else begin
      vld_q  <= {vld_q[DivLat-1:0], ctl.valid};
      sing_q <= {sing_q[DivLat-1:0], ctl.singular};
    end
  end

  // Merge stage.
  always_comb begin
    logic s;
    s = sing_q[DivLat];
    done_o = vld_q[DivLat];
    out_o.inv00 = s ? '0 : el[0]; out_o.inv01 = s ? '0 : el[1];
    out_o.inv02 = s ? '0 : el[2]; out_o.inv10 = s ? '0 : el[3];
    out_o.inv11 = s ? '0 : el[4]; out_o.inv12 = s ? '0 : el[5];
    out_o.inv20 = s ? '0 : el[6]; out_o.inv21 = s ? '0 : el[7];
    out_o.inv22 = s ? '0 : el[8];
    out_o.singular = s;
    out_o.saturated = !s && (sat[0] || sat[1] || sat[2] || sat[3] || sat[4] ||
                             sat[5] || sat[6] || sat[7] || sat[8]);
  end

  `MI_ASSERT_IMPL(a_sing_sat, clk_i, rst_ni, done_o |-> !(out_o.singular && out_o.saturated))
  `MI_ASSERT_NEXT(a_front_lat, clk_i, rst_ni, ctl.valid, vld_q[0])
  `MI_ASSERT_IMPL(a_never_busy, clk_i, rst_ni, !busy)
endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for matrix_inverse_3x3: a scoreboard class predicts each
// inverse in exact wide integers and checks results in order. Depends on mi3_pkg.
`timescale 1ns / 1ps

module tb;
  import mi3_pkg::*;

  // Scoreboard: predicts the inverse of each accepted matrix and checks results.
  class inverse_scoreboard;
    logic [EpsW-1:0] epsilon;
    mi3_out_t pending_q[$];
    int errors;

    function new();
      epsilon = EpsReset;
      errors  = 0;
    endfunction

    // Exact adjugate-over-determinant, truncated toward zero, then clipped.
    function mi3_out_t invert(mi3_in_t mtx);
      logic signed [127:0] m[9];
      logic signed [127:0] cof[9];
      logic signed [127:0] det, mag, num, thr;
      logic [127:0] q;
      logic [31:0] elem[9];
      logic clipped;
      logic negative;
      mi3_out_t res;
      m[0] = mtx.a00; m[1] = mtx.a01; m[2] = mtx.a02;
      m[3] = mtx.a10; m[4] = mtx.a11; m[5] = mtx.a12;
      m[6] = mtx.a20; m[7] = mtx.a21; m[8] = mtx.a22;
      cof[0] = m[4]*m[8] - m[5]*m[7]; cof[1] = m[2]*m[7] - m[1]*m[8];
      cof[2] = m[1]*m[5] - m[2]*m[4]; cof[3] = m[5]*m[6] - m[3]*m[8];
      cof[4] = m[0]*m[8] - m[2]*m[6]; cof[5] = m[2]*m[3] - m[0]*m[5];
      cof[6] = m[3]*m[7] - m[4]*m[6]; cof[7] = m[1]*m[6] - m[0]*m[7];
      cof[8] = m[0]*m[4] - m[1]*m[3];
      det = m[0]*cof[0] + m[1]*cof[3] + m[2]*cof[6];
      mag = (det < 0) ? -det : det;
      thr = {65'd0, epsilon, 32'd0};
      res = '0;
      if (mag == 0 || mag < thr) begin
        res.singular = 1'b1;
        return res;
      end
      clipped = 1'b0;
      for (int k = 0; k < 9; k++) begin
        num = cof[k] <<< 32;
        negative = (num < 0) != (det < 0);
        q = ((num < 0) ? -num : num) / mag;
        if (negative) begin
          if (q > 128'h8000_0000) begin
            elem[k] = 32'h8000_0000;
            clipped = 1'b1;
          end else begin
            elem[k] = -q[31:0];
          end
        end else begin
          if (q > 128'h7FFF_FFFF) begin
            elem[k] = 32'h7FFF_FFFF;
            clipped = 1'b1;
          end else begin
            elem[k] = q[31:0];
          end
        end
      end
      res.inv00 = elem[0]; res.inv01 = elem[1]; res.inv02 = elem[2];
      res.inv10 = elem[3]; res.inv11 = elem[4]; res.inv12 = elem[5];
      res.inv20 = elem[6]; res.inv21 = elem[7]; res.inv22 = elem[8];
      res.saturated = clipped;
      return res;
    endfunction

    function void note_matrix(mi3_in_t mtx);
      pending_q.push_back(invert(mtx));
    endfunction

    function void check_inverse(mi3_out_t got);
      mi3_out_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.inv00 !== want.inv00) report_field("inv00", want.inv00, got.inv00);
      if (got.inv01 !== want.inv01) report_field("inv01", want.inv01, got.inv01);
      if (got.inv02 !== want.inv02) report_field("inv02", want.inv02, got.inv02);
      if (got.inv10 !== want.inv10) report_field("inv10", want.inv10, got.inv10);
      if (got.inv11 !== want.inv11) report_field("inv11", want.inv11, got.inv11);
      if (got.inv12 !== want.inv12) report_field("inv12", want.inv12, got.inv12);
      if (got.inv20 !== want.inv20) report_field("inv20", want.inv20, got.inv20);
      if (got.inv21 !== want.inv21) report_field("inv21", want.inv21, got.inv21);
      if (got.inv22 !== want.inv22) report_field("inv22", want.inv22, got.inv22);
      if (got.singular !== want.singular)
        report_field("singular", want.singular, got.singular);
      if (got.saturated !== want.saturated)
        report_field("saturated", want.saturated, got.saturated);
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  mi3_in_t in_i;
  logic done;
  mi3_out_t out_o;
  logic cfg_we;
  logic [EpsW-1:0] cfg_wdata;

  inverse_scoreboard board;
  int idle_pct;

  matrix_inverse_3x3 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Check every result transaction at the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni && done === 1'b1) begin
      board.check_inverse(out_o);
    end
  end

  // Present one matrix and hold it until the block accepts it. Start stays high
  // on return so that back-to-back transactions need no gap.
  task automatic send_matrix(mi3_in_t mtx);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    in_i  <= mtx;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    board.note_matrix(mtx);
    @(negedge clk_i);
  endtask

  // Write epsilon once the pipeline has drained.
  task automatic write_epsilon(logic [EpsW-1:0] value);
    start <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    board.epsilon = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 << 16)) - (1 << 16));
      2: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
      3: return 32'($signed($urandom_range(1 << 12)) - (1 << 11));
      4: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic mi3_in_t rand_matrix();
    mi3_in_t mtx;
    mtx = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
           rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    // Make some matrices singular by repeating a row.
    if ($urandom_range(9) == 0) begin
      mtx.a20 = mtx.a00; mtx.a21 = mtx.a01; mtx.a22 = mtx.a02;
    end
    return mtx;
  endfunction

  function automatic mi3_in_t diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
    mi3_in_t mtx;
    mtx = '0;
    mtx.a00 = d0; mtx.a11 = d1; mtx.a22 = d2;
    return mtx;
  endfunction

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    mi3_in_t mtx;
    board     = new();
    rst_ni    = 1'b0;
    start     = 1'b0;
    in_i      = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_pct  = 11;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: identity, scaled, all-zero, extremes, tiny and huge determinants.
    send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000));
    send_matrix('0);
    send_matrix('1);
    send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
    send_matrix(diag(32'h0000_0001, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'h0002_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'h8000_0000, 32'h0001_0000, 32'h0001_0000));
    mtx = {9{32'h8000_0000}};
    send_matrix(mtx);
    mtx = {9{32'h7FFF_FFFF}};
    send_matrix(mtx);
    mtx = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000,
           32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 32'h0000_0000};
    send_matrix(mtx);
    mtx = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
           32'h0006_0000, 32'h0007_0000, 32'h0008_0000, 32'h0009_0000};
    send_matrix(mtx);

    // Epsilon zero: only an exact zero determinant is singular.
    write_epsilon('0);
    send_matrix('0);
    send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    // Largest epsilon: nearly everything is singular.
    write_epsilon('1);
    send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));

    // Random phases under several epsilon settings and idle patterns.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: write_epsilon(EpsW'(1));
        1: write_epsilon(EpsW'($urandom_range(1 << 16)));
        default: write_epsilon(EpsW'($urandom()));
      endcase
      idle_pct = (phase < 2) ? 11 : (phase < 4) ? 86 : 0;
      for (int n = 0; n < 280; n++) begin
        send_matrix(rand_matrix());
      end
    end

    start <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog against a hung pipeline.
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/mi3_pkg.sv
rtl/core/mi3_lane.sv
rtl/core/mi3_front.sv
rtl/core/matrix_inverse_3x3.sv
test/tb.sv
